>>> design/ddmp_pkg.sv
// ----------------------------------------------------------------------------
// ddmp_pkg
// Shared constants for the decimal digit residue / modular power block:
// default widths, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package ddmp_pkg;

  // default widths of the modulus and exponent registers
  localparam int unsigned MOD_BITS_DEF = 31;
  localparam int unsigned EXP_BITS_DEF = 31;

  // input digit field width
  localparam int unsigned DIGIT_W = 4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

endpackage

>>> design/decimal_digit_mod_pow.sv
// ----------------------------------------------------------------------------
// decimal_digit_mod_pow
// Residue of a decimal number (one digit per transfer, most significant
// first) modulo a configured modulus, and that residue raised to a configured
// exponent modulo the same modulus, reported on the digit flagged last.
// ----------------------------------------------------------------------------
// Operation: every digit is folded in by a bit-serial long reduction of
// residue*10 + digit, one bit per cycle through a single compare-subtract; the
// input stalls until the digit is done. On the last digit the power follows by
// right-to-left square-and-multiply over each exponent bit up to the highest
// set bit, in which a bit-serial shift-and-add forms both the multiply and the
// square (they share the doubled multiplicand). The result sits in an output
// register, so a new number may start while it waits to be taken. A modulus of
// zero acts as one; configuration must be written only while the block is
// idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module decimal_digit_mod_pow #(
  parameter int unsigned MOD_BITS = ddmp_pkg::MOD_BITS_DEF,
  parameter int unsigned EXP_BITS = ddmp_pkg::EXP_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [ddmp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [((MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS)-1:0] cfg_data,
  // digit input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [ddmp_pkg::DIGIT_W-1:0]           in_digit,
  input  logic                                   in_last,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [MOD_BITS-1:0]                    out_residue,
  output logic [MOD_BITS-1:0]                    out_power
);

  localparam int unsigned VB    = MOD_BITS + 4;          // residue*10 + digit
  localparam int unsigned CNT_W = $clog2(VB);

  // state codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_EXP  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                last_r, last_nxt;
  logic [MOD_BITS-1:0] mod_r;
  logic [EXP_BITS-1:0] exp_r;
  logic [MOD_BITS-1:0] run_r, run_nxt;
  logic [VB-1:0]       vsh_r, vsh_nxt;
  logic [MOD_BITS-1:0] rem_r, rem_nxt;
  logic [MOD_BITS-1:0] res_r, res_nxt;
  logic [EXP_BITS-1:0] esh_r, esh_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] base_r, base_nxt;
  logic [MOD_BITS-1:0] mcand_r, mcand_nxt;
  logic [MOD_BITS-1:0] p1_r, p1_nxt;
  logic [MOD_BITS-1:0] p2_r, p2_nxt;
  logic [MOD_BITS-1:0] ma_r, ma_nxt;
  logic [MOD_BITS-1:0] mb_r, mb_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MOD_BITS-1:0] out_residue_r, out_power_r;

  logic [MOD_BITS-1:0] m_eff;
  logic [MOD_BITS:0]   m_ext;
  logic [MOD_BITS-1:0] one_mod;
  logic [MOD_BITS:0]   red_t, dbl_t, add1_t, add2_t;
  logic [MOD_BITS-1:0] red_q, dbl_q, add1_q, add2_q;
  logic [VB-1:0]       v_init;
  logic                in_xfer, slot_free, load_out;

  // effective modulus: zero acts as one
  always_comb begin
    m_eff   = (mod_r == '0) ? MOD_BITS'(1) : mod_r;
    m_ext   = {1'b0, m_eff};
    one_mod = (m_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
  end

  // reduction step: shift one bit of v into the remainder
  always_comb begin
    red_t = {rem_r, vsh_r[VB-1]};
    red_q = (red_t >= m_ext) ? MOD_BITS'(red_t - m_ext) : red_t[MOD_BITS-1:0];
  end

  // multiply step: double the multiplicand, add it into both products
  always_comb begin
    dbl_t  = {1'b0, mcand_r} + {1'b0, mcand_r};
    dbl_q  = (dbl_t >= m_ext) ? MOD_BITS'(dbl_t - m_ext) : dbl_t[MOD_BITS-1:0];
    add1_t = {1'b0, p1_r} + {1'b0, mcand_r};
    add1_q = (add1_t >= m_ext) ? MOD_BITS'(add1_t - m_ext) : add1_t[MOD_BITS-1:0];
    add2_t = {1'b0, p2_r} + {1'b0, mcand_r};
    add2_q = (add2_t >= m_ext) ? MOD_BITS'(add2_t - m_ext) : add2_t[MOD_BITS-1:0];
  end

  // residue*10 + digit, zero extended
  assign v_init = {1'b0, run_r, 3'b000} + {3'b000, run_r, 1'b0}
                + {{(VB-ddmp_pkg::DIGIT_W){1'b0}}, in_digit};

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign load_out  = (state_r == S_OUT) && slot_free;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    run_nxt   = run_r;
    vsh_nxt   = vsh_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    esh_nxt   = esh_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    mcand_nxt = mcand_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          vsh_nxt   = v_init;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(VB - 1);
          last_nxt  = in_last;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        rem_nxt = red_q;
        vsh_nxt = {vsh_r[VB-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (last_r) begin
            run_nxt   = '0;
            res_nxt   = red_q;
            acc_nxt   = one_mod;
            base_nxt  = red_q;
            esh_nxt   = exp_r;
            state_nxt = S_EXP;
          end else begin
            run_nxt   = red_q;
            state_nxt = S_IDLE;
          end
        end
      end
      S_EXP: begin
        // one exponent bit: start acc*base and base*base together
        if (esh_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          mcand_nxt = base_r;
          p1_nxt    = '0;
          p2_nxt    = '0;
          ma_nxt    = acc_r;
          mb_nxt    = base_r;
          cnt_nxt   = CNT_W'(MOD_BITS - 1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mcand_nxt = dbl_q;
        p1_nxt    = ma_r[0] ? add1_q : p1_r;
        p2_nxt    = mb_r[0] ? add2_q : p2_r;
        ma_nxt    = ma_r >> 1;
        mb_nxt    = mb_r >> 1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          acc_nxt   = esh_r[0] ? p1_nxt : acc_r;
          base_nxt  = p2_nxt;
          esh_nxt   = esh_r >> 1;
          state_nxt = S_EXP;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_BITS'(1);
      exp_r       <= EXP_BITS'(1);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == ddmp_pkg::REG_MODULUS) begin
        mod_r <= cfg_data[MOD_BITS-1:0];
      end
      if (cfg_we && cfg_index == ddmp_pkg::REG_EXPONENT) begin
        exp_r <= cfg_data[EXP_BITS-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    vsh_r   <= vsh_nxt;
    rem_r   <= rem_nxt;
    res_r   <= res_nxt;
    esh_r   <= esh_nxt;
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    mcand_r <= mcand_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    if (load_out) begin
      out_residue_r <= res_r;
      out_power_r   <= acc_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;
  assign out_power   = out_power_r;

`ifndef SYNTH
  // a result only appears after the power loop has finished
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result loaded outside the done state");

  // exhausted exponent goes straight to the result
  a_exp_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXP && esh_r == '0) |=> state_r == S_OUT)
    else $error("power loop did not finish on empty exponent");

  // running residue is cleared once the last digit has been folded in
  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXP || state_r == S_MUL || state_r == S_OUT) |-> run_r == '0)
    else $error("running residue not cleared after last digit");

  // a non-last digit returns to idle after its reduction
  a_red_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RED && cnt_r == '0 && !last_r) |=> state_r == S_IDLE)
    else $error("digit reduction did not return to idle");
`endif

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for decimal_digit_mod_pow. Decimal numbers go in one
// digit per transfer. A built-in predictor folds each accepted digit into its
// own running residue and, on the digit flagged last, queues the expected
// residue and modular power. Each result transfer is compared against the
// oldest queued pair. Directed cases come first, then random numbers under
// several modulus/exponent settings, with random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MOD_BITS = ddmp_pkg::MOD_BITS_DEF;
  localparam int unsigned EXP_BITS = ddmp_pkg::EXP_BITS_DEF;
  localparam int unsigned CFG_W = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS;
  localparam int unsigned IDX_W = ddmp_pkg::CFG_IDX_W;
  localparam int unsigned DIG_W = ddmp_pkg::DIGIT_W;
  // worst case for the last digit of a number: digit fold plus full exponent
  localparam int unsigned NUMBER_LAT = MOD_BITS + 5 + EXP_BITS * (MOD_BITS + 1) + 2;
  // slowest run: every number of one digit, each at worst latency, gap and stall
  localparam longint unsigned LIMIT = 4_000_000;
  localparam int unsigned RANDOM_DIGITS = 830;

  localparam logic [MOD_BITS-1:0] MOD_MAX = {MOD_BITS{1'b1}};
  localparam logic [EXP_BITS-1:0] EXP_MAX = {EXP_BITS{1'b1}};

  // stall patterns for the result side
  typedef enum int {STALL_NONE, STALL_SHORT, STALL_LONG} stall_mode_t;

  typedef bit [127:0] wide_t;
  typedef struct {
    logic [MOD_BITS-1:0] residue;
    logic [MOD_BITS-1:0] power;
  } number_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [IDX_W-1:0]     cfg_index = ddmp_pkg::REG_MODULUS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DIG_W-1:0]     in_digit = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MOD_BITS-1:0]  out_residue;
  logic [MOD_BITS-1:0]  out_power;

  // predictor state: register copies and running residue
  logic [MOD_BITS-1:0]  modulus_reg = MOD_BITS'(1);
  logic [EXP_BITS-1:0]  exponent_reg = EXP_BITS'(1);
  logic [MOD_BITS-1:0]  acc_residue = '0;
  number_result_t       pending_results[$];

  int unsigned          errors = 0;
  int unsigned          digits_sent = 0;
  int unsigned          numbers_sent = 0;
  int unsigned          results_checked = 0;
  int unsigned          settings_used = 0;
  longint unsigned      cycle_count = 0;

  // sender and receiver idling controls
  bit                   sender_gaps = 1'b0;
  int unsigned          burst_left = 0;
  stall_mode_t          stall_mode = STALL_NONE;
  int unsigned          stall_left = 0;
  bit                   stall_now = 1'b0;

  decimal_digit_mod_pow #(
    .MOD_BITS(MOD_BITS),
    .EXP_BITS(EXP_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_digit   (in_digit),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_residue(out_residue),
    .out_power  (out_power)
  );

  always #2ns clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // right-to-left square-and-multiply over every exponent bit
  function automatic wide_t pow_mod_n(wide_t base, logic [EXP_BITS-1:0] e, wide_t m);
    wide_t acc;
    acc = wide_t'(1) % m;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (e[i]) acc = (acc * base) % m;
      base = (base * base) % m;
    end
    return acc;
  endfunction

  // fold one accepted digit; a last digit queues the expected pair
  task automatic fold_digit(input logic [DIG_W-1:0] d, input logic l);
    wide_t m;
    wide_t r;
    wide_t p;
    number_result_t res;
    // zero modulus behaves as one
    m = (modulus_reg == '0) ? wide_t'(1) : wide_t'(modulus_reg);
    r = ((wide_t'(acc_residue) % m) * 10 + wide_t'(d)) % m;
    if (!l) begin
      acc_residue = r[MOD_BITS-1:0];
    end else begin
      p = pow_mod_n(r, exponent_reg, m);
      res.residue = r[MOD_BITS-1:0];
      res.power = p[MOD_BITS-1:0];
      pending_results.push_back(res);
      acc_residue = '0;
      numbers_sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    number_result_t want;
    if (stall_left == 0) begin
      unique case (stall_mode)
        STALL_SHORT: begin
          stall_now = ($urandom_range(99) < 30);
          stall_left = $urandom_range(1, 3);
        end
        STALL_LONG: begin
          stall_now = ($urandom_range(99) < 50);
          stall_left = $urandom_range(1, 24);
        end
        default: begin
          stall_now = 1'b0;
          stall_left = 1;
        end
      endcase
    end
    stall_left--;

    // transfer happens when valid is high and our stall was low
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, residue %0d power %0d",
                 $time, out_residue, out_power);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_residue !== want.residue) begin
          errors++;
          $display("%0t: residue expected %0d actual %0d", $time, want.residue, out_residue);
        end
        if (out_power !== want.power) begin
          errors++;
          $display("%0t: power expected %0d actual %0d", $time, want.power, out_power);
        end
      end
    end
    out_stall <= stall_now;
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // one digit transfer, with bursts and gaps on the sender side
  task automatic send_digit(input logic [DIG_W-1:0] d, input logic l);
    int unsigned gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_digit <= d;
    in_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_digit(d, l);
    digits_sent++;
  endtask

  // number written in hex characters, so A..F give the codes above nine
  task automatic send_digits(input string s);
    logic [DIG_W-1:0] d;
    for (int i = 0; i < s.len(); i++) begin
      d = (s[i] >= "A") ? DIG_W'(s[i] - "A" + 10) : DIG_W'(s[i] - "0");
      send_digit(d, i == s.len() - 1);
    end
  endtask

  // sender holds off until every queued result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // block idle: drained and any trailing digit work finished
  task automatic wait_idle();
    drain_results();
    repeat (NUMBER_LAT) @(posedge clk);
  endtask

  // one register write; the caller drops the write enable afterwards
  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == ddmp_pkg::REG_MODULUS) modulus_reg = val[MOD_BITS-1:0];
    else exponent_reg = val[EXP_BITS-1:0];
  endtask

  task automatic set_registers(input logic [CFG_W-1:0] modv, input logic [CFG_W-1:0] expv);
    wait_idle();
    write_reg(ddmp_pkg::REG_MODULUS, modv);
    write_reg(ddmp_pkg::REG_EXPONENT, expv);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random_number(input int unsigned len);
    logic [DIG_W-1:0] d;
    for (int unsigned i = 0; i < len; i++) begin
      d = ($urandom_range(99) < 10) ? DIG_W'($urandom_range(10, 15))
                                    : DIG_W'($urandom_range(0, 9));
      send_digit(d, i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values: modulus 1 and exponent 1 give zero everywhere
  task automatic test_reset_values();
    sender_gaps = 1'b0;
    stall_mode = STALL_SHORT;
    send_digits("123");
    settings_used++;
  endtask

  // largest modulus and exponent, residue at its top value
  task automatic test_field_extremes();
    set_registers(CFG_W'(MOD_MAX), CFG_W'(EXP_MAX));
    send_digits("99");
    send_digits("0");
    send_digits("2147483646");
  endtask

  task automatic test_zero_modulus();
    set_registers('0, CFG_W'(5));
    send_digits("95");
  endtask

  // codes 10 to 15 fold in at face value
  task automatic test_wide_digits();
    set_registers(CFG_W'(1000), CFG_W'(3));
    send_digits("FA");
    send_digits("C");
  endtask

  // power is 1 mod n, including zero to the zero; 0 when n is one
  task automatic test_zero_exponent();
    set_registers(CFG_W'(13), '0);
    send_digits("0");
    send_digits("26");
    send_digits("5");
    set_registers(CFG_W'(1), '0);
    send_digits("8");
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] modv, input logic [CFG_W-1:0] expv,
                                  input int unsigned budget, input bit gaps,
                                  input stall_mode_t smode);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    set_registers(modv, expv);
    sender_gaps = gaps;
    stall_mode = smode;
    start = digits_sent;
    while (digits_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 60) len = $urandom_range(1, 4);
      else if (pick < 90) len = $urandom_range(5, 12);
      else len = $urandom_range(13, 40);
      send_random_number(len);
      // occasional full hold-off on the sender side
      if ($urandom_range(99) < 4) drain_results();
    end
  endtask

  task automatic test_random_numbers();
    int unsigned per_phase;
    per_phase = RANDOM_DIGITS / 6;
    run_random_phase(CFG_W'(MOD_MAX), CFG_W'($urandom()), per_phase, 1'b1, STALL_SHORT);
    run_random_phase(CFG_W'($urandom_range(2, 100)), CFG_W'($urandom_range(0, 20)),
                     per_phase, 1'b0, STALL_NONE);
    run_random_phase(CFG_W'($urandom()), CFG_W'($urandom()), per_phase, 1'b1, STALL_LONG);
    run_random_phase('0, CFG_W'($urandom()), per_phase, 1'b1, STALL_SHORT);
    run_random_phase(CFG_W'($urandom_range(1, 3)), CFG_W'(EXP_MAX), per_phase, 1'b0,
                     STALL_LONG);
    run_random_phase(CFG_W'(1) << (MOD_BITS - 1), CFG_W'($urandom()), per_phase, 1'b1,
                     STALL_SHORT);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_field_extremes();
    test_zero_modulus();
    test_wide_digits();
    test_zero_exponent();
    test_random_numbers();

    drain_results();
    repeat (NUMBER_LAT) @(posedge clk);

    $display("Covered %0d digits in %0d numbers, %0d results checked, %0d register settings.",
             digits_sent, numbers_sent, results_checked, settings_used);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
